FILE: hdl/bgpp_pkg.sv
// ----------------------------------------------------------------------------
// bgpp_pkg
// Shared types and constants for the BGP path-attribute parser.
// ----------------------------------------------------------------------------
package bgpp_pkg;

   localparam int unsigned MAX_ASNS            = 128;
   localparam int unsigned MAX_SEGMENTS        = 32;
   localparam int unsigned MAX_COMMUNITY_ITEMS = 128;
   localparam int unsigned MAX_PREFIXES        = 128;

   localparam logic [7:0]  EXT_LEN_FLAG   = 8'h10;
   localparam logic [15:0] ATTR_LEN_LIMIT = 16'd4096;
   localparam logic [7:0]  PFX_LIMIT      = 8'd128;

   localparam int unsigned QUEUE_DEPTH = 4;
   localparam int unsigned QUEUE_AW    = $clog2(QUEUE_DEPTH);

   typedef enum logic [3:0] {
      EV_ORIGIN   = 4'd0,
      EV_SEGMENT  = 4'd1,
      EV_ASN      = 4'd2,
      EV_COMM     = 4'd3,
      EV_EXT      = 4'd4,
      EV_LARGE    = 4'd5,
      EV_NH4      = 4'd6,
      EV_NH6      = 4'd7,
      EV_REACH    = 4'd8,
      EV_WITHDRAW = 4'd9,
      EV_DONE     = 4'd10,
      EV_ERROR    = 4'd11
   } event_kind_type;

   // attribute type codes
   localparam logic [7:0] AT_ORIGIN     = 8'd1;
   localparam logic [7:0] AT_AS_PATH    = 8'd2;
   localparam logic [7:0] AT_NEXT_HOP   = 8'd3;
   localparam logic [7:0] AT_COMMUNITY  = 8'd8;
   localparam logic [7:0] AT_REACH_NLRI = 8'd14;
   localparam logic [7:0] AT_MP_UNREACH = 8'd15;
   localparam logic [7:0] AT_EXT_COMM   = 8'd16;
   localparam logic [7:0] AT_AS4_PATH   = 8'd17;
   localparam logic [7:0] AT_LARGE_COMM = 8'd32;

   typedef enum logic [4:0] {
      PH_IDLE      = 5'd0,
      PH_FLAGS     = 5'd1,
      PH_TYPE      = 5'd2,
      PH_LEN_HI    = 5'd3,
      PH_LEN_LO    = 5'd4,
      PH_SKIP      = 5'd5,
      PH_ORIGIN    = 5'd6,
      PH_SEG_TYPE  = 5'd7,
      PH_SEG_LEN   = 5'd8,
      PH_ASN       = 5'd9,
      PH_COMM      = 5'd10,
      PH_NH        = 5'd11,
      PH_MP_FIRST  = 5'd12,
      PH_MP_AFI    = 5'd13,
      PH_MP_NHLEN  = 5'd14,
      PH_MP_NH     = 5'd15,
      PH_MP_RSV    = 5'd16,
      PH_UNR_HDR   = 5'd17,
      PH_PFX_LEN   = 5'd18,
      PH_PFX_BYTES = 5'd19
   } phase_type;

   typedef struct packed {
      logic [7:0]  data_byte;
      logic        first_byte;
      logic [15:0] block_length;
      logic        as_path_two_byte;
      logic        prefixes_ipv6;
   } req_type;

   typedef struct packed {
      logic [3:0]  event_kind;
      logic [7:0]  attribute_code;
      logic [63:0] value_high;
      logic [63:0] value_low;
      logic [7:0]  prefix_length;
      logic        last;
   } rsp_type;

   // events caused by one byte
   typedef struct packed {
      rsp_type ev0;
      rsp_type ev1;
      logic    two;
   } entry_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

endpackage

FILE: hdl/bgpp_front.sv
// ----------------------------------------------------------------------------
// bgpp_front
// Byte parser: walks attribute headers and bodies, builds up to two events.
// ----------------------------------------------------------------------------
module bgpp_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               accept,
   input  bgpp_pkg::req_type  req,
   output logic               push,
   output bgpp_pkg::entry_type entry
);

   bgpp_pkg::phase_type phase_ff, phase_in;
   logic [15:0]  block_rem_ff, block_rem_in;
   logic [7:0]   flags_ff, flags_in;
   logic [7:0]   atype_ff, atype_in;
   logic [12:0]  attr_rem_ff, attr_rem_in;
   logic [7:0]   field_rem_ff, field_rem_in;
   logic [127:0] fs_ff, fs_in;
   logic [7:0]   pend_plen_ff, pend_plen_in;
   logic [7:0]   asn_cnt_ff, asn_cnt_in;
   logic [5:0]   seg_cnt_ff, seg_cnt_in;
   logic [7:0]   comm_cnt_ff, comm_cnt_in;
   logic [7:0]   reach_cnt_ff, reach_cnt_in;
   logic [7:0]   wd_cnt_ff, wd_cnt_in;
   logic [4:0]   fidx_ff, fidx_in;
   logic         asn2_ff, asn2_in;
   logic [3:0]   item_size_ff, item_size_in;
   logic [7:0]   seg_kind_ff, seg_kind_in;
   logic         two_ff, two_in;
   logic         v6_ff, v6_in;

   bgpp_pkg::rsp_type ev [2];
   logic [1:0]  n;
   logic        err, chk, go;
   logic [7:0]  b;
   logic [15:0] len;
   logic [8:0]  plen_up;
   logic [3:0]  asn_w;

   function automatic bgpp_pkg::rsp_type mk(input bgpp_pkg::event_kind_type k,
         input logic [7:0] code, input logic [63:0] hi, input logic [63:0] lo,
         input logic [7:0] plen);
      bgpp_pkg::rsp_type r;
      r.event_kind     = k;
      r.attribute_code = (k == bgpp_pkg::EV_DONE) ? 8'd0 : code;
      r.value_high     = hi;
      r.value_low      = lo;
      r.prefix_length  = plen;
      r.last           = 1'b0;
      return r;
   endfunction

   always_comb begin
      phase_in = phase_ff;       block_rem_in = block_rem_ff;
      flags_in = flags_ff;       atype_in = atype_ff;
      attr_rem_in = attr_rem_ff; field_rem_in = field_rem_ff;
      fs_in = fs_ff;             pend_plen_in = pend_plen_ff;
      asn_cnt_in = asn_cnt_ff;   seg_cnt_in = seg_cnt_ff;
      comm_cnt_in = comm_cnt_ff; reach_cnt_in = reach_cnt_ff;
      wd_cnt_in = wd_cnt_ff;     fidx_in = fidx_ff;
      asn2_in = asn2_ff;         item_size_in = item_size_ff;
      seg_kind_in = seg_kind_ff; two_in = two_ff;
      v6_in = v6_ff;
      ev[0] = '0; ev[1] = '0;
      n = 2'd0; err = 1'b0; chk = 1'b0; go = 1'b0;
      b = req.data_byte;
      len = '0; plen_up = '0;
      asn_w = asn2_ff ? 4'd2 : 4'd4;
      if (accept) begin
         go = 1'b1;
         if (req.first_byte) begin
            phase_in = bgpp_pkg::PH_IDLE; flags_in = '0; atype_in = '0;
            attr_rem_in = '0; field_rem_in = '0; fs_in = '0; pend_plen_in = '0;
            asn_cnt_in = '0; seg_cnt_in = '0; comm_cnt_in = '0;
            reach_cnt_in = '0; wd_cnt_in = '0; fidx_in = '0; asn2_in = 1'b0;
            item_size_in = 4'd4; seg_kind_in = '0;
            block_rem_in = req.block_length;
            two_in = req.as_path_two_byte;
            v6_in = req.prefixes_ipv6;
            if (req.block_length == 16'd0) begin
               ev[0] = mk(bgpp_pkg::EV_DONE, 8'd0, '0, '0, 8'd0);
               n = 2'd1;
               go = 1'b0;
            end else begin
               phase_in = bgpp_pkg::PH_FLAGS;
            end
         end
         if (go && phase_in != bgpp_pkg::PH_IDLE) begin
            block_rem_in = block_rem_in - 16'd1;
            unique case (phase_in)
               bgpp_pkg::PH_FLAGS: begin
                  flags_in = b;
                  phase_in = bgpp_pkg::PH_TYPE;
               end
               bgpp_pkg::PH_TYPE: begin
                  atype_in = b;
                  fs_in[127:64] = '0;
                  phase_in = ((flags_in & bgpp_pkg::EXT_LEN_FLAG) != 8'd0) ?
                             bgpp_pkg::PH_LEN_HI : bgpp_pkg::PH_LEN_LO;
               end
               bgpp_pkg::PH_LEN_HI: begin
                  fs_in[127:64] = {56'd0, b};
                  phase_in = bgpp_pkg::PH_LEN_LO;
               end
               bgpp_pkg::PH_LEN_LO: begin
                  len = {fs_in[71:64], b};
                  if (len > bgpp_pkg::ATTR_LEN_LIMIT || len > block_rem_in) begin
                     err = 1'b1;
                  end else begin
                     unique case (atype_in)
                        bgpp_pkg::AT_ORIGIN: phase_in = bgpp_pkg::PH_ORIGIN;
                        bgpp_pkg::AT_AS_PATH, bgpp_pkg::AT_AS4_PATH: begin
                           asn2_in = (atype_in == bgpp_pkg::AT_AS_PATH) && two_in;
                           asn_cnt_in = '0;
                           seg_cnt_in = '0;
                           phase_in = bgpp_pkg::PH_SEG_TYPE;
                        end
                        bgpp_pkg::AT_NEXT_HOP: begin
                           if (len != 16'd4) begin
                              err = 1'b1;
                           end else begin
                              fs_in = '0; fidx_in = '0;
                              phase_in = bgpp_pkg::PH_NH;
                           end
                        end
                        bgpp_pkg::AT_COMMUNITY, bgpp_pkg::AT_EXT_COMM,
                        bgpp_pkg::AT_LARGE_COMM: begin
                           item_size_in = (atype_in == bgpp_pkg::AT_COMMUNITY) ? 4'd4 :
                                          (atype_in == bgpp_pkg::AT_EXT_COMM) ? 4'd8 : 4'd12;
                           fs_in = '0; fidx_in = '0;
                           phase_in = bgpp_pkg::PH_COMM;
                        end
                        bgpp_pkg::AT_REACH_NLRI: phase_in = bgpp_pkg::PH_MP_FIRST;
                        bgpp_pkg::AT_MP_UNREACH: begin
                           field_rem_in = 8'd3;
                           phase_in = bgpp_pkg::PH_UNR_HDR;
                        end
                        default: phase_in = bgpp_pkg::PH_SKIP;
                     endcase
                     if (!err) begin
                        attr_rem_in = len[12:0];
                        if (len == 16'd0) chk = 1'b1;
                     end
                  end
               end
               default: begin
                  unique case (phase_in)
                     bgpp_pkg::PH_SKIP: ;
                     bgpp_pkg::PH_ORIGIN: begin
                        ev[n[0]] = mk(bgpp_pkg::EV_ORIGIN, atype_in, '0, {56'd0, b}, 8'd0);
                        n = n + 2'd1;
                        phase_in = bgpp_pkg::PH_SKIP;
                     end
                     bgpp_pkg::PH_SEG_TYPE: begin
                        seg_kind_in = b;
                        phase_in = bgpp_pkg::PH_SEG_LEN;
                     end
                     bgpp_pkg::PH_SEG_LEN: begin
                        if (seg_cnt_in < 6'(bgpp_pkg::MAX_SEGMENTS)) begin
                           seg_cnt_in = seg_cnt_in + 6'd1;
                           ev[n[0]] = mk(bgpp_pkg::EV_SEGMENT, atype_in, '0,
                                         {48'd0, seg_kind_in, b}, 8'd0);
                           n = n + 2'd1;
                        end
                        field_rem_in = b;
                        fidx_in = '0;
                        fs_in[63:0] = '0;
                        phase_in = (b != 8'd0) ? bgpp_pkg::PH_ASN : bgpp_pkg::PH_SEG_TYPE;
                     end
                     bgpp_pkg::PH_ASN: begin
                        asn_w = asn2_in ? 4'd2 : 4'd4;
                        fs_in[63:0] = {32'd0, fs_in[23:0], b};
                        fidx_in = fidx_in + 5'd1;
                        if (fidx_in >= {1'b0, asn_w}) begin
                           if (asn_cnt_in < 8'(bgpp_pkg::MAX_ASNS)) begin
                              asn_cnt_in = asn_cnt_in + 8'd1;
                              ev[n[0]] = mk(bgpp_pkg::EV_ASN, atype_in, '0, fs_in[63:0], 8'd0);
                              n = n + 2'd1;
                           end
                           fidx_in = '0;
                           fs_in[63:0] = '0;
                           field_rem_in = field_rem_in - 8'd1;
                           if (field_rem_in == 8'd0) phase_in = bgpp_pkg::PH_SEG_TYPE;
                        end
                     end
                     bgpp_pkg::PH_COMM: begin
                        if (fidx_in < 5'd16) fs_in[127 - 8*fidx_in[3:0] -: 8] =
                           fs_in[127 - 8*fidx_in[3:0] -: 8] | b;
                        if (fidx_in != 5'd31) fidx_in = fidx_in + 5'd1;
                        if (fidx_in >= {1'b0, item_size_in}) begin
                           if (comm_cnt_in < 8'(bgpp_pkg::MAX_COMMUNITY_ITEMS)) begin
                              comm_cnt_in = comm_cnt_in + 8'd1;
                              if (item_size_in == 4'd4)
                                 ev[n[0]] = mk(bgpp_pkg::EV_COMM, atype_in, '0,
                                               {32'd0, fs_in[127:96]}, 8'd0);
                              else if (item_size_in == 4'd8)
                                 ev[n[0]] = mk(bgpp_pkg::EV_EXT, atype_in, '0,
                                               fs_in[127:64], 8'd0);
                              else
                                 ev[n[0]] = mk(bgpp_pkg::EV_LARGE, atype_in, fs_in[127:64],
                                               fs_in[63:0], 8'd0);
                              n = n + 2'd1;
                           end
                           fs_in = '0; fidx_in = '0;
                        end
                     end
                     bgpp_pkg::PH_NH: begin
                        if (fidx_in < 5'd16) fs_in[127 - 8*fidx_in[3:0] -: 8] =
                           fs_in[127 - 8*fidx_in[3:0] -: 8] | b;
                        if (fidx_in != 5'd31) fidx_in = fidx_in + 5'd1;
                        if (fidx_in >= 5'd4) begin
                           ev[n[0]] = mk(bgpp_pkg::EV_NH4, atype_in, '0,
                                         {32'd0, fs_in[127:96]}, 8'd0);
                           n = n + 2'd1;
                           phase_in = bgpp_pkg::PH_SKIP;
                        end
                     end
                     bgpp_pkg::PH_MP_FIRST, bgpp_pkg::PH_MP_NHLEN: begin
                        if (b != 8'd0 || phase_in == bgpp_pkg::PH_MP_NHLEN) begin
                           field_rem_in = b;
                           pend_plen_in = b;
                           fs_in = '0; fidx_in = '0;
                           phase_in = (b != 8'd0) ? bgpp_pkg::PH_MP_NH : bgpp_pkg::PH_MP_RSV;
                        end else begin
                           field_rem_in = 8'd2;
                           phase_in = bgpp_pkg::PH_MP_AFI;
                        end
                     end
                     bgpp_pkg::PH_MP_AFI: begin
                        field_rem_in = field_rem_in - 8'd1;
                        if (field_rem_in == 8'd0) phase_in = bgpp_pkg::PH_MP_NHLEN;
                     end
                     bgpp_pkg::PH_MP_NH: begin
                        if (fidx_in < 5'd16) fs_in[127 - 8*fidx_in[3:0] -: 8] =
                           fs_in[127 - 8*fidx_in[3:0] -: 8] | b;
                        if (fidx_in != 5'd31) fidx_in = fidx_in + 5'd1;
                        field_rem_in = field_rem_in - 8'd1;
                        if (field_rem_in == 8'd0) begin
                           if (pend_plen_in == 8'd4) begin
                              ev[n[0]] = mk(bgpp_pkg::EV_NH4, atype_in, '0,
                                            {32'd0, fs_in[127:96]}, 8'd0);
                              n = n + 2'd1;
                           end else if (pend_plen_in == 8'd16 || pend_plen_in == 8'd32) begin
                              ev[n[0]] = mk(bgpp_pkg::EV_NH6, atype_in, fs_in[127:64],
                                            fs_in[63:0], 8'd0);
                              n = n + 2'd1;
                           end
                           phase_in = bgpp_pkg::PH_MP_RSV;
                        end
                     end
                     bgpp_pkg::PH_MP_RSV: phase_in = bgpp_pkg::PH_PFX_LEN;
                     bgpp_pkg::PH_UNR_HDR: begin
                        field_rem_in = field_rem_in - 8'd1;
                        if (field_rem_in == 8'd0) phase_in = bgpp_pkg::PH_PFX_LEN;
                     end
                     bgpp_pkg::PH_PFX_LEN, bgpp_pkg::PH_PFX_BYTES: begin
                        if (phase_in == bgpp_pkg::PH_PFX_LEN) begin
                           if (b > bgpp_pkg::PFX_LIMIT) begin
                              err = 1'b1;
                           end else begin
                              pend_plen_in = b;
                              fs_in = '0; fidx_in = '0;
                              plen_up = {1'b0, b} + 9'd7;
                              field_rem_in = {2'd0, plen_up[8:3]};
                              if (field_rem_in != 8'd0) phase_in = bgpp_pkg::PH_PFX_BYTES;
                           end
                        end else begin
                           if (fidx_in < 5'd16) fs_in[127 - 8*fidx_in[3:0] -: 8] =
                              fs_in[127 - 8*fidx_in[3:0] -: 8] | b;
                           if (fidx_in != 5'd31) fidx_in = fidx_in + 5'd1;
                           field_rem_in = field_rem_in - 8'd1;
                           if (field_rem_in == 8'd0) phase_in = bgpp_pkg::PH_PFX_LEN;
                        end
                        // prefix complete: report it if under the cap
                        if (!err && field_rem_in == 8'd0) begin
                           if (atype_in == bgpp_pkg::AT_REACH_NLRI) begin
                              if (reach_cnt_in < 8'(bgpp_pkg::MAX_PREFIXES)) begin
                                 reach_cnt_in = reach_cnt_in + 8'd1;
                                 ev[n[0]] = mk(bgpp_pkg::EV_REACH, atype_in,
                                    v6_in ? fs_in[127:64] : 64'd0,
                                    v6_in ? fs_in[63:0] : {32'd0, fs_in[127:96]},
                                    pend_plen_in);
                                 n = n + 2'd1;
                              end
                           end else if (wd_cnt_in < 8'(bgpp_pkg::MAX_PREFIXES)) begin
                              wd_cnt_in = wd_cnt_in + 8'd1;
                              ev[n[0]] = mk(bgpp_pkg::EV_WITHDRAW, atype_in,
                                 v6_in ? fs_in[127:64] : 64'd0,
                                 v6_in ? fs_in[63:0] : {32'd0, fs_in[127:96]},
                                 pend_plen_in);
                              n = n + 2'd1;
                           end
                        end
                     end
                     default: err = 1'b1;
                  endcase
                  if (!err) begin
                     if (attr_rem_in != 13'd0) attr_rem_in = attr_rem_in - 13'd1;
                     if (attr_rem_in == 13'd0) chk = 1'b1;
                  end
               end
            endcase
            if (!err && chk) begin
               if (phase_in == bgpp_pkg::PH_SKIP || phase_in == bgpp_pkg::PH_ORIGIN ||
                   phase_in == bgpp_pkg::PH_SEG_TYPE || phase_in == bgpp_pkg::PH_COMM ||
                   phase_in == bgpp_pkg::PH_PFX_LEN) begin
                  phase_in = bgpp_pkg::PH_FLAGS;
                  atype_in = '0;
               end else begin
                  err = 1'b1;
               end
            end
            if (!err && block_rem_in == 16'd0) begin
               if (phase_in == bgpp_pkg::PH_FLAGS) begin
                  ev[n[0]] = mk(bgpp_pkg::EV_DONE, atype_in, '0, '0, 8'd0);
                  n = n + 2'd1;
                  phase_in = bgpp_pkg::PH_IDLE;
               end else begin
                  err = 1'b1;
               end
            end
            if (err) begin
               ev[n[0]] = mk(bgpp_pkg::EV_ERROR, atype_in, '0, '0, 8'd0);
               n = n + 2'd1;
               phase_in = bgpp_pkg::PH_IDLE;
            end
         end
      end
      if (n == 2'd2) ev[1].last = 1'b1;
      else ev[0].last = 1'b1;
      push = (n != 2'd0);
      entry.ev0 = ev[0];
      entry.ev1 = ev[1];
      entry.two = (n == 2'd2);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= bgpp_pkg::PH_IDLE;
         block_rem_ff <= '0; flags_ff <= '0; atype_ff <= '0; attr_rem_ff <= '0;
         field_rem_ff <= '0; fs_ff <= '0; pend_plen_ff <= '0; asn_cnt_ff <= '0;
         seg_cnt_ff <= '0; comm_cnt_ff <= '0; reach_cnt_ff <= '0; wd_cnt_ff <= '0;
         fidx_ff <= '0; asn2_ff <= 1'b0; item_size_ff <= 4'd4; seg_kind_ff <= '0;
         two_ff <= 1'b0; v6_ff <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         block_rem_ff <= block_rem_in; flags_ff <= flags_in; atype_ff <= atype_in;
         attr_rem_ff <= attr_rem_in; field_rem_ff <= field_rem_in; fs_ff <= fs_in;
         pend_plen_ff <= pend_plen_in; asn_cnt_ff <= asn_cnt_in; seg_cnt_ff <= seg_cnt_in;
         comm_cnt_ff <= comm_cnt_in; reach_cnt_ff <= reach_cnt_in; wd_cnt_ff <= wd_cnt_in;
         fidx_ff <= fidx_in; asn2_ff <= asn2_in; item_size_ff <= item_size_in;
         seg_kind_ff <= seg_kind_in; two_ff <= two_in; v6_ff <= v6_in;
      end
   end

endmodule

FILE: hdl/bgpp_queue.sv
// ----------------------------------------------------------------------------
// bgpp_queue
// Short queue of per-byte event entries between parser and output stage.
// ----------------------------------------------------------------------------
module bgpp_queue (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        push,
   input  bgpp_pkg::entry_type         push_entry,
   input  logic                        pop,
   output bgpp_pkg::entry_type         head,
   output bgpp_pkg::queue_status_type  status
);

   bgpp_pkg::entry_type mem [bgpp_pkg::QUEUE_DEPTH];
   logic [bgpp_pkg::QUEUE_AW-1:0] wp_ff, wp_in, rp_ff, rp_in;
   logic [bgpp_pkg::QUEUE_AW:0]   cnt_ff, cnt_in;

   always_comb begin
      wp_in  = push ? wp_ff + 1'b1 : wp_ff;
      rp_in  = pop  ? rp_ff + 1'b1 : rp_ff;
      cnt_in = cnt_ff + (push ? 1'b1 : 1'b0) - (pop ? 1'b1 : 1'b0);
      status.full  = (cnt_ff == (bgpp_pkg::QUEUE_AW+1)'(bgpp_pkg::QUEUE_DEPTH));
      status.empty = (cnt_ff == '0);
      head = mem[rp_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= '0;
         rp_ff <= '0;
         cnt_ff <= '0;
      end else begin
         wp_ff <= wp_in;
         rp_ff <= rp_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) mem[wp_ff] <= push_entry;
   end

endmodule

FILE: hdl/bgpp_back.sv
// ----------------------------------------------------------------------------
// bgpp_back
// Output stage: holds one entry and hands out its one or two events.
// ----------------------------------------------------------------------------
module bgpp_back (
   input  logic                        clock,
   input  logic                        reset,
   input  bgpp_pkg::entry_type         head,
   input  bgpp_pkg::queue_status_type  status,
   output logic                        pop,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output bgpp_pkg::rsp_type           rsp_data
);

   bgpp_pkg::entry_type hold_ff, hold_in;
   logic hv_ff, hv_in, idx_ff, idx_in, xfer, done_ent;

   always_comb begin
      xfer     = hv_ff && !rsp_stall;
      done_ent = xfer && (idx_ff == hold_ff.two);
      pop      = (!hv_ff || done_ent) && !status.empty;
      hold_in  = pop ? head : hold_ff;
      hv_in    = pop ? 1'b1 : (done_ent ? 1'b0 : hv_ff);
      idx_in   = pop ? 1'b0 : ((xfer && !done_ent) ? 1'b1 : idx_ff);
      rsp_valid = hv_ff;
      rsp_data  = idx_ff ? hold_ff.ev1 : hold_ff.ev0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hv_ff <= 1'b0;
         idx_ff <= 1'b0;
      end else begin
         hv_ff <= hv_in;
         idx_ff <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      hold_ff <= hold_in;
   end

endmodule

FILE: hdl/bgp_path_attribute_parser.sv
// ----------------------------------------------------------------------------
// bgp_path_attribute_parser
// Byte-wide BGP path-attribute decoder emitting one event per decoded field.
// ----------------------------------------------------------------------------
// Takes one byte of the attribute block per transfer and decodes it in the
// same cycle; each byte yields zero, one or two events (an item followed by
// done or error). Bytes enter at one per cycle as long as the event queue
// (four entries) has room; the output stage hands out a byte's events one
// after the other. Each event passes through the queue and then the output
// stage's hold register. first_byte restarts parsing at any time.
module bgp_path_attribute_parser (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  bgpp_pkg::req_type   req_data,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output bgpp_pkg::rsp_type   rsp_data
);

   logic                       accept;
   logic                       push;
   logic                       pop;
   bgpp_pkg::entry_type        push_entry;
   bgpp_pkg::entry_type        head;
   bgpp_pkg::queue_status_type status;

   // stall only on a full queue, so parsing waits on the output side only once the queue fills
   assign req_stall = status.full;
   assign accept    = req_valid && !req_stall;

   bgpp_front u_front (
      .clock  (clock),
      .reset  (reset),
      .accept (accept),
      .req    (req_data),
      .push   (push),
      .entry  (push_entry)
   );

   bgpp_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .head       (head),
      .status     (status)
   );

   bgpp_back u_back (
      .clock     (clock),
      .reset     (reset),
      .head      (head),
      .status    (status),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

FILE: hdl/bgpp_checker.sv
// ----------------------------------------------------------------------------
// bgpp_checker
// Port-level checks for the path-attribute parser.
// ----------------------------------------------------------------------------
module bgpp_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_stall,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input bgpp_pkg::rsp_type rsp_data
);

   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_stall |=> req_valid)
      else $error("stalled byte withdrawn");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result changed");

   a_end_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.event_kind == bgpp_pkg::EV_DONE ||
                    rsp_data.event_kind == bgpp_pkg::EV_ERROR) |-> rsp_data.last)
      else $error("done or error without last");

   a_done_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.event_kind == bgpp_pkg::EV_DONE |->
         rsp_data.attribute_code == 8'd0)
      else $error("done carries attribute code");

   a_pfx_len: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.prefix_length <= bgpp_pkg::PFX_LIMIT)
      else $error("prefix length out of range");

endmodule

bind bgp_path_attribute_parser bgpp_checker u_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

FILE: verif/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the BGP path-attribute parser.
// ----------------------------------------------------------------------------
// Byte transfers come from a queue that an initial block fills with directed
// attribute blocks and then random blocks, mostly well-formed, with some corruption.
// Each accepted byte runs through a local decoder model; its events are queued
// and compared field by field with every event transfer on the output side.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_top;
   import bgpp_pkg::*;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_stall;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_stall;
   rsp_type rsp_data;

   bgp_path_attribute_parser u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always begin
      clock = 1'b0;
      #6;
      clock = 1'b1;
      #6;
   end

   // ------------------------------------------------------------------------
   // Decoder model state
   // ------------------------------------------------------------------------
   phase_type   phase;
   logic [15:0] blk_left;
   logic [7:0]  attr_flags;
   logic [7:0]  attr_code;
   logic [15:0] attr_left;
   logic [7:0]  fld_left;
   logic [63:0] acc_hi, acc_lo;
   logic [7:0]  pend_len;
   logic [7:0]  n_asn, n_seg, n_comm, n_reach, n_wdraw;
   logic [7:0]  acc_idx;
   logic [7:0]  asn_bytes;
   logic [7:0]  comm_bytes;
   logic [7:0]  seg_kind;
   logic        mode_2byte, mode_v6;

   rsp_type  expected_events[$];
   req_type  pending_bytes[$];
   rsp_type  byte_events[$];
   int       errors = 0;
   logic     stim_done;

   function automatic void model_clear();
      phase = PH_IDLE; blk_left = '0; attr_flags = '0; attr_code = '0;
      attr_left = '0; fld_left = '0; acc_hi = '0; acc_lo = '0; pend_len = '0;
      n_asn = '0; n_seg = '0; n_comm = '0; n_reach = '0; n_wdraw = '0;
      acc_idx = '0; asn_bytes = 8'd4; comm_bytes = 8'd4; seg_kind = '0;
      mode_2byte = 1'b0; mode_v6 = 1'b0;
   endfunction

   function automatic void add_event(event_kind_type k, logic [63:0] hi, logic [63:0] lo,
                                     logic [7:0] plen);
      rsp_type r;
      r.event_kind     = k;
      r.attribute_code = (k == EV_DONE) ? 8'd0 : attr_code;
      r.value_high     = hi;
      r.value_low      = lo;
      r.prefix_length  = plen;
      r.last           = 1'b0;
      byte_events.push_back(r);
   endfunction

   function automatic void acc_reset();
      acc_hi = '0; acc_lo = '0; acc_idx = '0;
   endfunction

   function automatic void acc_put(logic [7:0] b);
      if (acc_idx < 8)       acc_hi |= {56'd0, b} << (56 - 8 * acc_idx);
      else if (acc_idx < 16) acc_lo |= {56'd0, b} << (56 - 8 * (acc_idx - 8));
      if (acc_idx < 255) acc_idx++;
   endfunction

   function automatic void nh_begin(logic [7:0] len);
      fld_left = len;
      pend_len = len;
      acc_reset();
      phase = (len != 0) ? PH_MP_NH : PH_MP_RSV;
   endfunction

   function automatic void prefix_out();
      logic is_reach;
      is_reach = (attr_code == AT_REACH_NLRI);
      if ((is_reach ? n_reach : n_wdraw) < MAX_PREFIXES) begin
         if (is_reach) n_reach++; else n_wdraw++;
         if (mode_v6)
            add_event(is_reach ? EV_REACH : EV_WITHDRAW, acc_hi, acc_lo, pend_len);
         else
            add_event(is_reach ? EV_REACH : EV_WITHDRAW, 64'd0, acc_hi >> 32, pend_len);
      end
   endfunction

   // Sets the body phase for the attribute just read; 0 when a NEXT_HOP length is not 4.
   function automatic logic body_begin(logic [15:0] len);
      case (attr_code)
         AT_ORIGIN: phase = PH_ORIGIN;
         AT_AS_PATH, AT_AS4_PATH: begin
            asn_bytes = (attr_code == AT_AS_PATH && mode_2byte) ? 8'd2 : 8'd4;
            n_asn = '0; n_seg = '0;
            phase = PH_SEG_TYPE;
         end
         AT_NEXT_HOP: begin
            if (len != 16'd4) return 1'b0;
            acc_reset();
            phase = PH_NH;
         end
         AT_COMMUNITY, AT_EXT_COMM, AT_LARGE_COMM: begin
            comm_bytes = (attr_code == AT_COMMUNITY) ? 8'd4 :
                         (attr_code == AT_EXT_COMM) ? 8'd8 : 8'd12;
            acc_reset();
            phase = PH_COMM;
         end
         AT_REACH_NLRI: phase = PH_MP_FIRST;
         AT_MP_UNREACH: begin
            fld_left = 8'd3;
            phase = PH_UNR_HDR;
         end
         default: phase = PH_SKIP;
      endcase
      return 1'b1;
   endfunction

   // Runs one byte through the decoder, leaving its events in byte_events.
   function automatic void decode_byte(req_type it);
      logic       err, at_end;
      logic [7:0] b;
      logic [15:0] len;
      err = 1'b0; at_end = 1'b0; b = it.data_byte;
      byte_events.delete();
      if (it.first_byte) begin
         model_clear();
         blk_left = it.block_length;
         mode_2byte = it.as_path_two_byte;
         mode_v6 = it.prefixes_ipv6;
         if (blk_left == 0) begin
            add_event(EV_DONE, 0, 0, 0);
            byte_events[0].last = 1'b1;
            return;
         end
         phase = PH_FLAGS;
      end
      if (phase == PH_IDLE) return;
      blk_left--;
      case (phase)
         PH_FLAGS: begin
            attr_flags = b;
            phase = PH_TYPE;
         end
         PH_TYPE: begin
            attr_code = b;
            acc_hi = '0;
            phase = (attr_flags & EXT_LEN_FLAG) ? PH_LEN_HI : PH_LEN_LO;
         end
         PH_LEN_HI: begin
            acc_hi = {56'd0, b};
            phase = PH_LEN_LO;
         end
         PH_LEN_LO: begin
            len = {acc_hi[7:0], b};
            if (len > ATTR_LEN_LIMIT || len > blk_left || !body_begin(len))
               err = 1'b1;
            else begin
               attr_left = len;
               if (len == 0) at_end = 1'b1;
            end
         end
         default: begin
            case (phase)
               PH_SKIP: ;
               PH_ORIGIN: begin
                  add_event(EV_ORIGIN, 0, {56'd0, b}, 0);
                  phase = PH_SKIP;
               end
               PH_SEG_TYPE: begin
                  seg_kind = b;
                  phase = PH_SEG_LEN;
               end
               PH_SEG_LEN: begin
                  if (n_seg < MAX_SEGMENTS) begin
                     n_seg++;
                     add_event(EV_SEGMENT, 0, {48'd0, seg_kind, b}, 0);
                  end
                  fld_left = b; acc_idx = '0; acc_lo = '0;
                  phase = (b != 0) ? PH_ASN : PH_SEG_TYPE;
               end
               PH_ASN: begin
                  acc_lo = {32'd0, acc_lo[23:0], b};
                  acc_idx++;
                  if (acc_idx >= asn_bytes) begin
                     if (n_asn < MAX_ASNS) begin
                        n_asn++;
                        add_event(EV_ASN, 0, acc_lo, 0);
                     end
                     acc_idx = '0; acc_lo = '0;
                     fld_left--;
                     if (fld_left == 0) phase = PH_SEG_TYPE;
                  end
               end
               PH_COMM: begin
                  acc_put(b);
                  if (acc_idx >= comm_bytes) begin
                     if (n_comm < MAX_COMMUNITY_ITEMS) begin
                        n_comm++;
                        if (comm_bytes == 4)      add_event(EV_COMM, 0, acc_hi >> 32, 0);
                        else if (comm_bytes == 8) add_event(EV_EXT, 0, acc_hi, 0);
                        else                      add_event(EV_LARGE, acc_hi, acc_lo, 0);
                     end
                     acc_reset();
                  end
               end
               PH_NH: begin
                  acc_put(b);
                  if (acc_idx >= 4) begin
                     add_event(EV_NH4, 0, acc_hi >> 32, 0);
                     phase = PH_SKIP;
                  end
               end
               PH_MP_FIRST: begin
                  if (b != 0) nh_begin(b);
                  else begin
                     fld_left = 8'd2;
                     phase = PH_MP_AFI;
                  end
               end
               PH_MP_AFI: begin
                  fld_left--;
                  if (fld_left == 0) phase = PH_MP_NHLEN;
               end
               PH_MP_NHLEN: nh_begin(b);
               PH_MP_NH: begin
                  acc_put(b);
                  fld_left--;
                  if (fld_left == 0) begin
                     if (pend_len == 4) add_event(EV_NH4, 0, acc_hi >> 32, 0);
                     else if (pend_len == 16 || pend_len == 32)
                        add_event(EV_NH6, acc_hi, acc_lo, 0);
                     phase = PH_MP_RSV;
                  end
               end
               PH_MP_RSV: phase = PH_PFX_LEN;
               PH_UNR_HDR: begin
                  fld_left--;
                  if (fld_left == 0) phase = PH_PFX_LEN;
               end
               PH_PFX_LEN: begin
                  if (b > PFX_LIMIT) err = 1'b1;
                  else begin
                     pend_len = b;
                     acc_reset();
                     fld_left = 8'((9'(b) + 9'd7) >> 3);
                     if (fld_left == 0) prefix_out();
                     else phase = PH_PFX_BYTES;
                  end
               end
               PH_PFX_BYTES: begin
                  acc_put(b);
                  fld_left--;
                  if (fld_left == 0) begin
                     prefix_out();
                     phase = PH_PFX_LEN;
                  end
               end
               default: err = 1'b1;
            endcase
            if (!err) begin
               if (attr_left > 0) attr_left--;
               if (attr_left == 0) at_end = 1'b1;
            end
         end
      endcase
      if (!err && at_end) begin
         if (phase inside {PH_SKIP, PH_ORIGIN, PH_SEG_TYPE, PH_COMM, PH_PFX_LEN}) begin
            phase = PH_FLAGS;
            attr_code = '0;
         end else
            err = 1'b1;
      end
      if (!err && blk_left == 0) begin
         if (phase == PH_FLAGS) begin
            add_event(EV_DONE, 0, 0, 0);
            phase = PH_IDLE;
         end else
            err = 1'b1;
      end
      if (err) begin
         add_event(EV_ERROR, 0, 0, 0);
         phase = PH_IDLE;
      end
      if (byte_events.size() > 0) byte_events[byte_events.size() - 1].last = 1'b1;
   endfunction

   // ------------------------------------------------------------------------
   // Stimulus construction: attribute blocks as byte lists
   // ------------------------------------------------------------------------
   logic [7:0] blk_bytes[$];
   int         n_queued;
   logic       blk_two;

   function automatic void put_attr(logic [7:0] code, logic [7:0] body[$], logic ext);
      blk_bytes.push_back(ext ? 8'h50 : 8'h40);
      blk_bytes.push_back(code);
      if (ext) blk_bytes.push_back(8'(body.size() >> 8));
      blk_bytes.push_back(8'(body.size()));
      foreach (body[i]) blk_bytes.push_back(body[i]);
   endfunction

   // Queues blk_bytes as one block; len_adj skews the declared block length.
   function automatic void send_block(logic two, logic v6, int len_adj);
      req_type r;
      int      blen;
      blen = blk_bytes.size() + len_adj;
      if (blen < 0) blen = 0;
      foreach (blk_bytes[i]) begin
         r.data_byte        = blk_bytes[i];
         r.first_byte       = (i == 0);
         r.block_length     = 16'(blen);
         r.as_path_two_byte = $urandom_range(0, 1);
         r.prefixes_ipv6    = $urandom_range(0, 1);
         if (i == 0) begin
            r.as_path_two_byte = two;
            r.prefixes_ipv6 = v6;
         end
         pending_bytes.push_back(r);
      end
      n_queued += blk_bytes.size();
      blk_bytes.delete();
   endfunction

   function automatic void rand_bytes(ref logic [7:0] q[$], input int n);
      repeat (n) q.push_back(8'($urandom_range(0, 255)));
   endfunction

   function automatic void rand_prefixes(ref logic [7:0] q[$], input int cnt, input logic v6);
      int pl;
      repeat (cnt) begin
         pl = v6 ? $urandom_range(0, 128) : $urandom_range(0, 32);
         q.push_back(8'(pl));
         rand_bytes(q, (pl + 7) / 8);
      end
   endfunction

   // One random attribute of a random kind; one with a random code may be malformed.
   function automatic void rand_attr(logic v6);
      logic [7:0] body[$];
      logic [7:0] code;
      int         k, n, w;
      k = $urandom_range(0, 9);
      case (k)
         0: begin code = AT_ORIGIN; rand_bytes(body, $urandom_range(0, 2)); end
         1, 2: begin
            code = (k == 1) ? AT_AS_PATH : AT_AS4_PATH;
            w = (k == 1 && blk_two) ? 2 : 4;
            repeat ($urandom_range(0, 3)) begin
               n = $urandom_range(0, 4);
               body.push_back(8'($urandom_range(1, 4)));
               body.push_back(8'(n));
               rand_bytes(body, n * w);
            end
         end
         3: begin code = AT_NEXT_HOP; rand_bytes(body, 4); end
         4: begin code = AT_COMMUNITY; rand_bytes(body, 4 * $urandom_range(0, 4)); end
         5: begin code = AT_EXT_COMM; rand_bytes(body, 8 * $urandom_range(0, 3)); end
         6: begin
            code = AT_LARGE_COMM;
            rand_bytes(body, 12 * $urandom_range(0, 2) + $urandom_range(0, 1) * 5);
         end
         7: begin
            code = AT_REACH_NLRI;
            n = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 33) :
                (v6 ? 16 : 4) * (1 + $urandom_range(0, 1));
            if ($urandom_range(0, 1)) begin
               body.push_back(8'd0); rand_bytes(body, 2); body.push_back(8'(n));
            end else begin
               if (n == 0) n = 4;
               body.push_back(8'(n));
            end
            rand_bytes(body, n);
            body.push_back(8'd0);
            rand_prefixes(body, $urandom_range(0, 3), v6);
         end
         8: begin
            code = AT_MP_UNREACH;
            rand_bytes(body, 3);
            rand_prefixes(body, $urandom_range(0, 3), v6);
         end
         default: begin code = 8'($urandom_range(0, 255)); rand_bytes(body, $urandom_range(0, 6)); end
      endcase
      put_attr(code, body, $urandom_range(0, 3) == 0);
   endfunction

   // ------------------------------------------------------------------------
   // Stimulus
   // ------------------------------------------------------------------------
   initial begin
      logic [7:0] b[$];
      logic       v6;
      int         dice;
      n_queued = 0;
      blk_two = 1'b0;
      stim_done = 1'b0;

      // empty block, then an idle byte that must be ignored
      blk_bytes.push_back(8'hff); send_block(0, 0, -1);
      pending_bytes.push_back('{8'h00, 1'b0, 16'hffff, 1'b1, 1'b1});
      // origin, empty origin, AS_PATH with 2-byte ASNs
      b = '{8'd2}; put_attr(AT_ORIGIN, b, 0);
      b.delete(); put_attr(AT_ORIGIN, b, 1);
      b = '{8'd2, 8'd2, 8'hff, 8'hff, 8'h00, 8'h01}; put_attr(AT_AS_PATH, b, 0);
      send_block(1, 0, 0);
      // next hop, communities with tail, compressed reach v6, unreach
      b = '{8'd10, 8'd0, 8'd0, 8'd1}; put_attr(AT_NEXT_HOP, b, 0);
      b = '{8'hff, 8'hff, 8'hff, 8'h01, 8'h07}; put_attr(AT_COMMUNITY, b, 0);
      b = '{8'd16}; rand_bytes(b, 16); b.push_back(8'd0); b.push_back(8'd128);
      rand_bytes(b, 16); put_attr(AT_REACH_NLRI, b, 0);
      b = '{8'd0, 8'd1, 8'd1, 8'd0}; put_attr(AT_MP_UNREACH, b, 0);
      send_block(0, 1, 0);
      // bad next-hop length, prefix length over 128, length over 4096, overrun
      b = '{8'd1, 8'd2, 8'd3}; put_attr(AT_NEXT_HOP, b, 0); send_block(0, 0, 0);
      b = '{8'd0, 8'd1, 8'd1, 8'd129}; put_attr(AT_MP_UNREACH, b, 0); send_block(0, 0, 0);
      blk_bytes = '{8'h50, 8'd99, 8'h10, 8'h01}; send_block(0, 0, 5000);
      b = '{8'd1, 8'd2}; put_attr(AT_ORIGIN, b, 0); send_block(0, 0, -1);

      // cap check: an AS_PATH with more segments and ASNs than are kept
      b.delete();
      repeat (3) begin
         b.push_back(8'd2); b.push_back(8'd44); rand_bytes(b, 88);
      end
      repeat (31) begin
         b.push_back(8'd1); b.push_back(8'd0);
      end
      put_attr(AT_AS_PATH, b, 1);
      send_block(1, 0, 0);

      // random blocks; a few are corrupted or cut short
      while (n_queued < 650) begin
         v6 = $urandom_range(0, 1);
         blk_two = $urandom_range(0, 1);
         repeat ($urandom_range(1, 4)) rand_attr(v6);
         dice = $urandom_range(0, 9);
         if (dice == 0) blk_bytes[$urandom_range(0, blk_bytes.size() - 1)] = 8'($urandom);
         if (dice == 1 && blk_bytes.size() > 2)
            blk_bytes = blk_bytes[0:$urandom_range(1, blk_bytes.size() - 2)];
         send_block(blk_two, v6, (dice == 2) ? $urandom_range(0, 3) : 0);
      end
      stim_done = 1'b1;
   end

   // ------------------------------------------------------------------------
   // Driver: one byte per transfer with a random gap before each
   // ------------------------------------------------------------------------
   int  req_gap;
   int  rsp_gap;

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         req_data  <= '0;
         req_gap   <= $urandom_range(0, 12);
      end else begin
         if (req_valid && !req_stall) begin
            decode_byte(req_data);
            foreach (byte_events[i]) expected_events.push_back(byte_events[i]);
         end
         if (!req_valid || !req_stall) begin
            if (req_gap > 0 || pending_bytes.size() == 0) begin
               req_valid <= 1'b0;
               if (req_gap > 0) req_gap <= req_gap - 1;
            end else begin
               req_valid <= 1'b1;
               req_data  <= pending_bytes.pop_front();
               // long runs without gaps too
               req_gap   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 12);
            end
         end
      end
   end

   // ------------------------------------------------------------------------
   // Monitor: random stall periods, event check against the model
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      rsp_type want;
      int      gap;
      if (reset) begin
         rsp_stall <= 1'b0;
         rsp_gap   <= 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_events.size() == 0) begin
               $display("%0t: unexpected event %p", $time, rsp_data);
               errors++;
            end else begin
               want = expected_events.pop_front();
               if (rsp_data !== want) begin
                  $display("%0t: event mismatch expected %p actual %p", $time, want, rsp_data);
                  errors++;
               end
            end
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 12);
            rsp_gap <= gap;
            rsp_stall <= (gap > 0);
         end else if (rsp_gap > 0) begin
            rsp_gap <= rsp_gap - 1;
            rsp_stall <= (rsp_gap > 1);
         end else
            rsp_stall <= 1'b0;
      end
   end

   // ------------------------------------------------------------------------
   // Reset, end of run
   // ------------------------------------------------------------------------
   initial begin
      model_clear();
      reset = 1'b1;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      wait (stim_done && pending_bytes.size() == 0);
      @(posedge clock);
      while (req_valid || expected_events.size() > 0) @(posedge clock);
      repeat (40) @(posedge clock);
      if (errors == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

   initial begin
      #2000000;
      $display("Test completed with failures");
      $finish;
   end

endmodule
